### rtl/json_key_value_extractor_macros.svh
// ---------------------------------------------------------------------------
// JSON key/value extractor assertion macros
// Concurrent check helpers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_EXTRACTOR_MACROS_SVH
`define JSON_KEY_VALUE_EXTRACTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define JKVE_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jkve assertion failed");
// next-cycle implication, sampled on clk, off during rst
`define JKVE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jkve assertion failed");
`else
`define JKVE_ASSERT(label, ante, cons)
`define JKVE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/jkve_pkg.sv
// ---------------------------------------------------------------------------
// jkve_pkg
// Shared types and constants of the JSON key/value extractor.
// ---------------------------------------------------------------------------
package jkve_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT  = 3'd5;

  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [15:0] VALUE_LIMIT_RESET = 16'd512;

  // characters of interest
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_NAME,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  // scalar configuration seen by the scanner
  typedef struct packed {
    logic [5:0]  key_length;
    logic [15:0] value_limit;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       scan_done;
    logic       key_found;
  } result_t;

endpackage

### rtl/jkve_scan.sv
// ---------------------------------------------------------------------------
// jkve_scan
// Per-byte scanner: name matching, value delimiting by depth counters and
// result generation, one byte per cycle.
// ---------------------------------------------------------------------------
module jkve_scan
  import jkve_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 32,
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic [7:0] key_bytes [KEY_BYTES],
  input  cfg_t       cfg,
  output result_t    res,
  output logic       res_valid
);

  localparam int unsigned KPOS_W = $clog2(KEY_BYTES + 1);
  localparam int unsigned KIDX_W = $clog2(KEY_BYTES);
  localparam int unsigned BR_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned BK_W   = BR_W + 1;
  localparam logic [BR_W-1:0]        BR_MAX = BR_W'(MAX_DEPTH);
  localparam logic signed [BK_W-1:0] BK_MAX = BK_W'(MAX_DEPTH);
  localparam logic signed [BK_W-1:0] BK_MIN = -BK_MAX;
  localparam logic signed [BK_W-1:0] BK_ONE = BK_W'(1);

  // state
  phase_t                   phase, phase_next;
  logic [KPOS_W-1:0]        key_position, key_position_next;
  logic                     name_mismatch, name_mismatch_next;
  logic                     emitting_match, emitting_match_next;
  logic [BR_W-1:0]          brace_depth, brace_depth_next;
  logic signed [BK_W-1:0]   bracket_depth, bracket_depth_next;
  logic [15:0]              emitted_count, emitted_count_next;
  logic                     scan_finished, scan_finished_next;

  // decode
  logic [KPOS_W-1:0] klen;
  logic [KPOS_W-1:0] pos_eff;
  logic              mis_eff;
  logic              lead_skip;
  logic              in_name;
  logic              in_value;
  logic [7:0]        key_at;
  logic              char_ok;
  logic              name_match;
  logic              is_colon;
  logic              is_ignored;
  logic              brace_zero;
  logic              brace_one;
  logic              end_incl;
  logic              end_excl;
  logic              emit;
  logic              done;
  logic              found;

  // clamp key length to the stored key
  assign klen = (cfg.key_length > 6'(KEY_BYTES)) ? KPOS_W'(KEY_BYTES)
                                                 : KPOS_W'(cfg.key_length);

  // classify the byte against the current phase
  always_comb begin
    lead_skip  = (phase == PH_LEAD) && (text_byte == CH_SPACE || text_byte == CH_LBRACE);
    in_name    = ((phase == PH_LEAD) && !lead_skip) || (phase == PH_NAME);
    in_value   = (phase == PH_VALUE);
    pos_eff    = (phase == PH_LEAD) ? '0 : key_position;
    mis_eff    = (phase == PH_LEAD) ? 1'b0 : name_mismatch;
    key_at     = key_bytes[pos_eff[KIDX_W-1:0]];
    char_ok    = !mis_eff && (pos_eff < klen) && (key_at == text_byte);
    name_match = !mis_eff && (pos_eff == klen);
    is_colon   = (text_byte == CH_COLON);
    is_ignored = (text_byte == CH_QUOTE) || (text_byte == CH_SPACE);
    brace_zero = (brace_depth == '0);
    brace_one  = (brace_depth == BR_W'(1));
    end_incl   = in_value && (((text_byte == CH_RBRACE) && brace_one) ||
                              ((text_byte == CH_RBRACKET) && (bracket_depth == BK_ONE)));
    end_excl   = in_value && (((text_byte == CH_RBRACE) && brace_zero) ||
                              ((text_byte == CH_COMMA) && brace_zero &&
                               (bracket_depth == '0)));
    emit       = !scan_finished && in_value && !end_excl && emitting_match &&
                 (emitted_count < cfg.value_limit);
    done       = !scan_finished &&
                 (end_of_text || (in_value && emitting_match && (end_excl || end_incl)));
    if (in_name) begin
      found = is_colon ? name_match : (klen == '0);
    end else if (in_value) begin
      found = emitting_match;
    end else begin
      found = 1'b0;
    end
  end

  // next state
  always_comb begin
    phase_next          = phase;
    key_position_next   = key_position;
    name_mismatch_next  = name_mismatch;
    emitting_match_next = emitting_match;
    brace_depth_next    = brace_depth;
    bracket_depth_next  = bracket_depth;
    emitted_count_next  = emitted_count;
    scan_finished_next  = scan_finished;
    if (item_valid) begin
      if (!scan_finished) begin
        if (in_name) begin
          phase_next         = PH_NAME;
          key_position_next  = pos_eff;
          name_mismatch_next = mis_eff;
          if (is_colon) begin
            // close the name and open its value
            emitting_match_next = name_match;
            phase_next          = PH_VALUE;
            brace_depth_next    = '0;
            bracket_depth_next  = '0;
            emitted_count_next  = '0;
          end else if (!is_ignored) begin
            if (char_ok) begin
              key_position_next = pos_eff + KPOS_W'(1);
            end else begin
              name_mismatch_next = 1'b1;
            end
          end
        end else begin
          case (phase)
            PH_SKIP: begin
              phase_next         = PH_NAME;
              key_position_next  = '0;
              name_mismatch_next = 1'b0;
            end
            PH_VALUE: begin
              // track nesting, saturating at the depth limit
              case (text_byte)
                CH_LBRACE: begin
                  if (brace_depth < BR_MAX) brace_depth_next = brace_depth + BR_W'(1);
                end
                CH_RBRACE: begin
                  if (!brace_zero && !brace_one) brace_depth_next = brace_depth - BR_W'(1);
                end
                CH_LBRACKET: begin
                  if (bracket_depth < BK_MAX) bracket_depth_next = bracket_depth + BK_ONE;
                end
                CH_RBRACKET: begin
                  if ((bracket_depth != BK_ONE) && (bracket_depth > BK_MIN)) begin
                    bracket_depth_next = bracket_depth - BK_ONE;
                  end
                end
                default: begin
                end
              endcase
              if (emit) emitted_count_next = emitted_count + 16'd1;
              if (end_excl && !emitting_match) begin
                phase_next         = PH_NAME;
                key_position_next  = '0;
                name_mismatch_next = 1'b0;
              end else if (!end_excl && end_incl && !emitting_match) begin
                phase_next = PH_SKIP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // last byte restarts the scan, an early finish holds until then
      if (end_of_text) begin
        phase_next          = PH_LEAD;
        key_position_next   = '0;
        name_mismatch_next  = 1'b0;
        emitting_match_next = 1'b0;
        brace_depth_next    = '0;
        bracket_depth_next  = '0;
        emitted_count_next  = '0;
        scan_finished_next  = 1'b0;
      end else if (done) begin
        scan_finished_next = 1'b1;
      end
    end
  end

  // result for this byte
  always_comb begin
    res.value_byte = emit ? text_byte : 8'd0;
    res.byte_valid = emit;
    res.scan_done  = done;
    res.key_found  = done && found;
    res_valid      = item_valid && (emit || done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD;
      key_position   <= '0;
      name_mismatch  <= 1'b0;
      emitting_match <= 1'b0;
      brace_depth    <= '0;
      bracket_depth  <= '0;
      emitted_count  <= '0;
      scan_finished  <= 1'b0;
    end else begin
      phase          <= phase_next;
      key_position   <= key_position_next;
      name_mismatch  <= name_mismatch_next;
      emitting_match <= emitting_match_next;
      brace_depth    <= brace_depth_next;
      bracket_depth  <= bracket_depth_next;
      emitted_count  <= emitted_count_next;
      scan_finished  <= scan_finished_next;
    end
  end

endmodule

### rtl/jkve_obuf.sv
// ---------------------------------------------------------------------------
// jkve_obuf
// Two-entry result buffer; keeps the output registered and lets the
// scanner take a byte while a result waits.
// ---------------------------------------------------------------------------
module jkve_obuf
  import jkve_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop        = (count != 2'd0) && !out_stall;
  assign count_next = count + 2'(push) - 2'(pop);
  assign full       = (count == 2'd2);
  assign out_valid  = (count != 2'd0);
  assign out_res    = entries[rd_ptr];

  // store incoming result
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_res;
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

endmodule

### rtl/json_key_value_extractor.sv
// ---------------------------------------------------------------------------
// json_key_value_extractor
// Scans JSON text a byte at a time and emits the value of the first name
// that equals the configured key, then a done result.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_stall  | text_byte, end_of_text
//   output   | out_valid / out_stall| value_byte, byte_valid, scan_done,
//            |                      | key_found
//   config   | cfg_write_en         | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; its result (if any) is registered.
// The scanner state updates in the cycle of acceptance; the two-entry result
// buffer sets in_stall only when both entries are held.
// Reset (rst, synchronous) clears scan state, key and key length registers;
// it sets the value limit to 512. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`include "json_key_value_extractor_macros.svh"

module json_key_value_extractor
  import jkve_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 32,
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            value_byte,
  output logic                  byte_valid,
  output logic                  scan_done,
  output logic                  key_found,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] key_bytes [KEY_BYTES];
  cfg_t       cfg;
  logic       item_valid;
  result_t    scan_res;
  logic       scan_res_valid;
  result_t    out_res;

  // key characters, eight to a register
  for (genvar k = 0; k < KEY_BYTES; k++) begin : g_key
    localparam logic [CFG_IDX_W-1:0] WORD = REG_KEY_LOW + CFG_IDX_W'(k / 8);
    always_ff @(posedge clk) begin
      if (rst) begin
        key_bytes[k] <= 8'd0;
      end else if (cfg_write_en && (cfg_index == WORD)) begin
        key_bytes[k] <= cfg_data[(k % 8) * 8 +: 8];
      end
    end
  end

  // scalar registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_length  <= 6'd0;
      cfg.value_limit <= VALUE_LIMIT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_KEY_LENGTH:  cfg.key_length  <= cfg_data[5:0];
        REG_VALUE_LIMIT: cfg.value_limit <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign item_valid = in_valid && !in_stall;

  jkve_scan #(
    .KEY_BYTES (KEY_BYTES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .key_bytes   (key_bytes),
    .cfg         (cfg),
    .res         (scan_res),
    .res_valid   (scan_res_valid)
  );

  jkve_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (scan_res_valid),
    .push_res  (scan_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign value_byte = out_res.value_byte;
  assign byte_valid = out_res.byte_valid;
  assign scan_done  = out_res.scan_done;
  assign key_found  = out_res.key_found;

  // checks
  `JKVE_ASSERT(a_stall_has_pending, in_stall, out_valid)
  `JKVE_ASSERT(a_found_only_when_done, out_valid && key_found, scan_done)
  `JKVE_ASSERT(a_byte_only_on_match, out_valid && byte_valid && scan_done, key_found)
  `JKVE_ASSERT_NEXT(a_full_no_overrun, in_stall && out_stall, in_stall)

endmodule
